[hdl/pobst_pkg.sv]
package pobst_pkg;

  // Sizing
  localparam int LIST_MAX    = 8;
  localparam int NUM_OWNERS  = 256;
  localparam int NUM_SLOTS   = 2 * NUM_OWNERS;
  localparam int NUM_ENTRIES = NUM_SLOTS * LIST_MAX;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ENT_AW      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(LIST_MAX + 1);

  // Fixed field widths
  localparam int ID_W     = 8;
  localparam int OWNER_W  = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 4;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CHECK  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 3'd0,
    ST_DUP        = 3'd1,
    ST_FULL       = 3'd2,
    ST_MISSING    = 3'd3,
    ST_INELIGIBLE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_CNT_RD,
    S_CNT_WAIT,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_RESP
  } state_e;

  // Requests from the sequencer to the list storage
  typedef struct packed {
    logic              ent_re;
    logic [ENT_AW-1:0] ent_raddr;
    logic              ent_we;
    logic [ENT_AW-1:0] ent_waddr;
    logic [ID_W-1:0]   ent_wdata;
    logic              cnt_re;
    logic [SLOT_W-1:0] cnt_raddr;
    logic              cnt_we;
    logic [SLOT_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
  } store_req_t;

  typedef struct packed {
    logic               present;
    status_e            status;
    logic [COUNT_W-1:0] count_after;
  } result_t;

endpackage

[hdl/pobst_store.sv]
// Entry memory and count memory, one write and one registered read each.
module pobst_store (
  input  logic                             clk_i,
  input  pobst_pkg::store_req_t            req_i,
  output logic [pobst_pkg::ID_W-1:0]       ent_rdata_o,
  output logic [pobst_pkg::CNT_W-1:0]      cnt_rdata_o
);

  logic [pobst_pkg::ID_W-1:0]  ent_mem [pobst_pkg::NUM_ENTRIES];
  logic [pobst_pkg::CNT_W-1:0] cnt_mem [pobst_pkg::NUM_SLOTS];
  logic [pobst_pkg::ID_W-1:0]  ent_rdata_q;
  logic [pobst_pkg::CNT_W-1:0] cnt_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.ent_we) begin
      ent_mem[req_i.ent_waddr] <= req_i.ent_wdata;
    end
    if (req_i.ent_re) begin
      ent_rdata_q <= ent_mem[req_i.ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.cnt_we) begin
      cnt_mem[req_i.cnt_waddr] <= req_i.cnt_wdata;
    end
    if (req_i.cnt_re) begin
      cnt_rdata_q <= cnt_mem[req_i.cnt_raddr];
    end
  end

  assign ent_rdata_o = ent_rdata_q;
  assign cnt_rdata_o = cnt_rdata_q;

endmodule

[hdl/pobst_seq.sv]
// Sequencer: count lookup, pipelined entry scan through one compare unit,
// decision, shift-down on remove, and count clearing sweep.
module pobst_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pobst_pkg::action_e                in_action_i,
  input  logic                              in_bank_i,
  input  logic [pobst_pkg::OWNER_W-1:0]     in_owner_i,
  input  logic [pobst_pkg::ID_W-1:0]        in_item_i,
  input  logic                              in_elig_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output pobst_pkg::result_t                res_o,
  output pobst_pkg::store_req_t             store_req_o,
  input  logic [pobst_pkg::ID_W-1:0]        ent_rdata_i,
  input  logic [pobst_pkg::CNT_W-1:0]       cnt_rdata_i
);

  pobst_pkg::state_e               state_q, state_d;
  logic                            sweep_resp_q, sweep_resp_d;
  logic [pobst_pkg::SLOT_W-1:0]    sweep_q, sweep_d;
  pobst_pkg::action_e              act_q, act_d;
  logic [pobst_pkg::ID_W-1:0]      item_q, item_d;
  logic                            elig_q, elig_d;
  logic [pobst_pkg::SLOT_W-1:0]    slot_q, slot_d;
  logic [pobst_pkg::ENT_AW-1:0]    base_q, base_d;
  logic [pobst_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [pobst_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic                            pv_q, pv_d;
  logic [pobst_pkg::CNT_W-1:0]     pp_q, pp_d;
  logic                            found_q, found_d;
  logic [pobst_pkg::CNT_W-1:0]     pos_q, pos_d;
  logic                            present_q, present_d;
  pobst_pkg::status_e              status_q, status_d;

  logic in_acc;
  logic oor;
  logic hit;
  logic more;
  logic shift_more;
  logic add_ok;
  logic rem_ok;
  logic need_shift;
  logic sweep_last;
  logic [pobst_pkg::SLOT_W-1:0] in_slot;

  assign in_acc     = in_valid_i && in_ready_o;
  assign oor        = 32'(in_owner_i) >= pobst_pkg::NUM_OWNERS;
  assign in_slot    = in_bank_i ? pobst_pkg::SLOT_W'(pobst_pkg::NUM_OWNERS)
                                  + pobst_pkg::SLOT_W'(in_owner_i)
                                : pobst_pkg::SLOT_W'(in_owner_i);
  // shared compare unit: data of last read vs. the searched id
  assign hit        = pv_q && (ent_rdata_i == item_q);
  assign more       = idx_q < cnt_q;
  // during the shift cnt_q holds the decremented count; walk up to the old one
  assign shift_more = idx_q < (cnt_q + 1'b1);
  assign add_ok     = (act_q == pobst_pkg::ACT_ADD) && elig_q
                      && (cnt_q < pobst_pkg::CNT_W'(pobst_pkg::LIST_MAX)) && !found_q;
  assign rem_ok     = (act_q == pobst_pkg::ACT_REMOVE) && found_q;
  assign need_shift = rem_ok && ((pos_q + 1'b1) < cnt_q);
  assign sweep_last = sweep_q == pobst_pkg::SLOT_W'(pobst_pkg::NUM_SLOTS - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pobst_pkg::S_SWEEP: begin
        if (sweep_last) begin
          state_d = sweep_resp_q ? pobst_pkg::S_RESP : pobst_pkg::S_IDLE;
        end
      end
      pobst_pkg::S_IDLE: begin
        if (in_valid_i) begin
          priority if (in_action_i == pobst_pkg::ACT_CLEAR) begin
            state_d = pobst_pkg::S_SWEEP;
          end else if (oor) begin
            state_d = pobst_pkg::S_RESP;
          end else begin
            state_d = pobst_pkg::S_CNT_RD;
          end
        end
      end
      pobst_pkg::S_CNT_RD:   state_d = pobst_pkg::S_CNT_WAIT;
      pobst_pkg::S_CNT_WAIT: state_d = pobst_pkg::S_SCAN;
      pobst_pkg::S_SCAN: begin
        if (hit || !more) begin
          state_d = pobst_pkg::S_DECIDE;
        end
      end
      pobst_pkg::S_DECIDE: begin
        state_d = need_shift ? pobst_pkg::S_SHIFT : pobst_pkg::S_RESP;
      end
      pobst_pkg::S_SHIFT: begin
        if (!shift_more && pv_q) begin
          state_d = pobst_pkg::S_RESP;
        end
      end
      pobst_pkg::S_RESP: begin
        if (res_ready_i) begin
          state_d = pobst_pkg::S_IDLE;
        end
      end
      default: state_d = pobst_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshake and storage requests
  always_comb begin
    store_req_o = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      pobst_pkg::S_SWEEP: begin
        store_req_o.cnt_we    = 1'b1;
        store_req_o.cnt_waddr = sweep_q;
      end
      pobst_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
      end
      pobst_pkg::S_CNT_RD: begin
        store_req_o.cnt_re    = 1'b1;
        store_req_o.cnt_raddr = slot_q;
      end
      pobst_pkg::S_SCAN: begin
        store_req_o.ent_re    = !hit && more;
        store_req_o.ent_raddr = base_q + pobst_pkg::ENT_AW'(idx_q);
      end
      pobst_pkg::S_DECIDE: begin
        store_req_o.cnt_waddr = slot_q;
        if (add_ok) begin
          store_req_o.ent_we    = 1'b1;
          store_req_o.ent_waddr = base_q + pobst_pkg::ENT_AW'(cnt_q);
          store_req_o.ent_wdata = item_q;
          store_req_o.cnt_we    = 1'b1;
          store_req_o.cnt_wdata = cnt_q + 1'b1;
        end else if (rem_ok) begin
          store_req_o.cnt_we    = 1'b1;
          store_req_o.cnt_wdata = cnt_q - 1'b1;
        end
      end
      pobst_pkg::S_SHIFT: begin
        // read entry idx, write the previously read one a place lower
        store_req_o.ent_re    = shift_more;
        store_req_o.ent_raddr = base_q + pobst_pkg::ENT_AW'(idx_q);
        store_req_o.ent_we    = pv_q;
        store_req_o.ent_waddr = base_q + pobst_pkg::ENT_AW'(pp_q) - 1'b1;
        store_req_o.ent_wdata = ent_rdata_i;
      end
      pobst_pkg::S_RESP: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    sweep_resp_d = sweep_resp_q;
    sweep_d      = sweep_q;
    act_d        = act_q;
    item_d       = item_q;
    elig_d       = elig_q;
    slot_d       = slot_q;
    base_d       = base_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    pv_d         = pv_q;
    pp_d         = pp_q;
    found_d      = found_q;
    pos_d        = pos_q;
    present_d    = present_q;
    status_d     = status_q;
    unique case (state_q)
      pobst_pkg::S_SWEEP: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) begin
          sweep_resp_d = 1'b0;
        end
      end
      pobst_pkg::S_IDLE: begin
        if (in_acc) begin
          act_d     = in_action_i;
          item_d    = in_item_i;
          elig_d    = in_elig_i;
          slot_d    = in_slot;
          cnt_d     = '0;
          present_d = 1'b0;
          found_d   = 1'b0;
          sweep_d   = '0;
          priority if (in_action_i == pobst_pkg::ACT_CLEAR) begin
            status_d     = pobst_pkg::ST_DONE;
            sweep_resp_d = 1'b1;
          end else if (in_action_i == pobst_pkg::ACT_ADD) begin
            status_d = in_elig_i ? pobst_pkg::ST_FULL : pobst_pkg::ST_INELIGIBLE;
          end else begin
            status_d = pobst_pkg::ST_MISSING;
          end
        end
      end
      pobst_pkg::S_CNT_RD: begin
        base_d = pobst_pkg::ENT_AW'(slot_q) * pobst_pkg::ENT_AW'(pobst_pkg::LIST_MAX);
      end
      pobst_pkg::S_CNT_WAIT: begin
        cnt_d = (cnt_rdata_i > pobst_pkg::CNT_W'(pobst_pkg::LIST_MAX))
                ? pobst_pkg::CNT_W'(pobst_pkg::LIST_MAX) : cnt_rdata_i;
        idx_d = '0;
        pv_d  = 1'b0;
      end
      pobst_pkg::S_SCAN: begin
        found_d = hit;
        pos_d   = pp_q;
        if (!hit && more) begin
          idx_d = idx_q + 1'b1;
          pv_d  = 1'b1;
          pp_d  = idx_q;
        end else begin
          pv_d = 1'b0;
        end
      end
      pobst_pkg::S_DECIDE: begin
        idx_d = pos_q + 1'b1;
        pv_d  = 1'b0;
        unique case (act_q)
          pobst_pkg::ACT_ADD: begin
            priority if (!elig_q) begin
              status_d  = pobst_pkg::ST_INELIGIBLE;
              present_d = found_q;
            end else if (cnt_q >= pobst_pkg::CNT_W'(pobst_pkg::LIST_MAX)) begin
              status_d  = pobst_pkg::ST_FULL;
              present_d = found_q;
            end else if (found_q) begin
              status_d  = pobst_pkg::ST_DUP;
              present_d = 1'b1;
            end else begin
              status_d  = pobst_pkg::ST_DONE;
              present_d = 1'b1;
              cnt_d     = cnt_q + 1'b1;
            end
          end
          pobst_pkg::ACT_REMOVE: begin
            present_d = 1'b0;
            if (found_q) begin
              status_d = pobst_pkg::ST_DONE;
              cnt_d    = cnt_q - 1'b1;
            end else begin
              status_d = pobst_pkg::ST_MISSING;
            end
          end
          pobst_pkg::ACT_CHECK: begin
            present_d = found_q;
            status_d  = found_q ? pobst_pkg::ST_DONE : pobst_pkg::ST_MISSING;
          end
          default: ;
        endcase
      end
      pobst_pkg::S_SHIFT: begin
        // cnt_q already holds the decremented count; compare against old count
        if (shift_more) begin
          idx_d = idx_q + 1'b1;
          pv_d  = 1'b1;
          pp_d  = idx_q;
        end else begin
          pv_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pobst_pkg::S_SWEEP;
      sweep_resp_q <= 1'b0;
      sweep_q      <= '0;
      pv_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_resp_q <= sweep_resp_d;
      sweep_q      <= sweep_d;
      pv_q         <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    item_q    <= item_d;
    elig_q    <= elig_d;
    slot_q    <= slot_d;
    base_q    <= base_d;
    cnt_q     <= cnt_d;
    idx_q     <= idx_d;
    pp_q      <= pp_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    present_q <= present_d;
    status_q  <= status_d;
  end

  assign res_o.present     = present_q;
  assign res_o.status      = status_q;
  assign res_o.count_after = pobst_pkg::COUNT_W'(cnt_q);

  a_scan_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pobst_pkg::S_SCAN && pv_q) |-> (pp_q < cnt_q))
    else $error("scan compare beyond list count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req_o.cnt_we |-> (store_req_o.cnt_wdata <= pobst_pkg::CNT_W'(pobst_pkg::LIST_MAX)))
    else $error("count write above list capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (store_req_o.ent_we && store_req_o.ent_re)
      |-> (store_req_o.ent_waddr != store_req_o.ent_raddr))
    else $error("entry read and write hit the same address");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != pobst_pkg::S_IDLE))
    else $error("sequencer idle right after accepting a transaction");

endmodule

[hdl/per_owner_bounded_set_table.sv]
// Two banks of per-owner lists of unique 8-bit ids, each list at most
// LIST_MAX (8) long, kept in insertion order. A transaction adds, removes,
// checks, or clears all lists, and returns one result: presence of the id
// after the operation, a status and the list length after it. The block
// works on one transaction at a time: a count read, a scan of the list
// entries, a decision and, for a remove that moves later entries down,
// a shift of those entries, then the result is handed over once the
// output register is free; the scan and shift both run through the
// single read port of the entry memory. After reset, and for every clear,
// a sweep zeroes the 512 list counts one per cycle while no input is
// taken. The result sits in an output register, so the next transaction
// is taken while the previous result waits on the output.
module per_owner_bounded_set_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input transactions
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] action, [2] bank, [10:3] owner_id, [18:11] item_id,
  // [19] owner_eligible, [23:20] zero
  input  logic [23:0] s_axis_tdata,
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] present, [3:1] status, [7:4] count_after
  output logic [7:0]  m_axis_tdata
);

  pobst_pkg::store_req_t             store_req;
  pobst_pkg::result_t                res;
  logic                              res_valid;
  logic                              res_ready;
  logic [pobst_pkg::ID_W-1:0]        ent_rdata;
  logic [pobst_pkg::CNT_W-1:0]       cnt_rdata;
  logic                              out_valid_q, out_valid_d;
  logic [7:0]                        out_data_q, out_data_d;

  pobst_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (pobst_pkg::action_e'(s_axis_tdata[1:0])),
    .in_bank_i   (s_axis_tdata[2]),
    .in_owner_i  (s_axis_tdata[10:3]),
    .in_item_i   (s_axis_tdata[18:11]),
    .in_elig_i   (s_axis_tdata[19]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .store_req_o (store_req),
    .ent_rdata_i (ent_rdata),
    .cnt_rdata_i (cnt_rdata)
  );

  pobst_store u_store (
    .clk_i       (clk_i),
    .req_i       (store_req),
    .ent_rdata_o (ent_rdata),
    .cnt_rdata_o (cnt_rdata)
  );

  // Output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = {res.count_after, res.status, res.present};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[sim/list_table_checker.sv]
`timescale 1ns / 100ps

module list_table_checker
  import pobst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [23:0] req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [7:0]  rsp_data_i,
  output int          errors_o,
  output int          pending_o
);

  // Shadow copy of both banks of owner lists
  logic [ID_W-1:0] list_ids [2][NUM_OWNERS][LIST_MAX];
  int              list_len [2][NUM_OWNERS];

  result_t predicted_results [$];
  int      mismatches = 0;

  assign errors_o  = mismatches;
  assign pending_o = predicted_results.size();

  task automatic report_fail(string msg);
    $display("[%0t] CHECK: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int find_id(int bnk, int own, int cnt, logic [ID_W-1:0] id);
    for (int i = 0; i < cnt; i++) begin
      if (list_ids[bnk][own][i] == id) return i;
    end
    return -1;
  endfunction

  // Applies one transaction to the shadow lists and returns its result
  function automatic result_t apply_list_op(logic [23:0] req);
    action_e         act;
    int              bnk;
    int              own;
    logic [ID_W-1:0] id;
    logic            elig;
    int              cnt;
    int              pos;
    result_t         r;
    act  = action_e'(req[1:0]);
    bnk  = int'(req[2]);
    own  = int'(req[10:3]);
    id   = req[18:11];
    elig = req[19];
    cnt  = 0;
    r.present = 1'b0;
    r.status  = ST_DONE;
    if (act == ACT_CLEAR) begin
      foreach (list_len[b, o]) list_len[b][o] = 0;
    end else if (own >= NUM_OWNERS) begin
      if (act == ACT_ADD) r.status = elig ? ST_FULL : ST_INELIGIBLE;
      else r.status = ST_MISSING;
    end else begin
      cnt = (list_len[bnk][own] > LIST_MAX) ? LIST_MAX : list_len[bnk][own];
      pos = find_id(bnk, own, cnt, id);
      case (act)
        ACT_ADD: begin
          if (!elig) r.status = ST_INELIGIBLE;
          else if (cnt >= LIST_MAX) r.status = ST_FULL;
          else if (pos >= 0) r.status = ST_DUP;
          else begin
            list_ids[bnk][own][cnt] = id;
            cnt++;
            list_len[bnk][own] = cnt;
          end
        end
        ACT_REMOVE: begin
          if (pos < 0) r.status = ST_MISSING;
          else begin
            for (int j = pos; j + 1 < cnt; j++) list_ids[bnk][own][j] = list_ids[bnk][own][j+1];
            cnt--;
            list_len[bnk][own] = cnt;
          end
        end
        default: r.status = (pos >= 0) ? ST_DONE : ST_MISSING;
      endcase
      r.present = (find_id(bnk, own, cnt, id) >= 0);
    end
    r.count_after = cnt[COUNT_W-1:0];
    return r;
  endfunction

  // Results first: a result can never belong to a request taken on the same edge
  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got_r;
    if (!rst_ni) begin
      predicted_results.delete();
      foreach (list_len[b, o]) list_len[b][o] = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        // tdata: [0] present, [3:1] status, [7:4] count_after
        got_r.present     = rsp_data_i[0];
        got_r.status      = status_e'(rsp_data_i[3:1]);
        got_r.count_after = rsp_data_i[7:4];
        if (predicted_results.size() == 0) begin
          report_fail($sformatf("result 0x%02h with nothing pending", rsp_data_i));
        end else begin
          exp_r = predicted_results.pop_front();
          if (got_r.present !== exp_r.present)
            report_fail($sformatf("present: exp %0d got %0d", exp_r.present, got_r.present));
          if (got_r.status !== exp_r.status)
            report_fail($sformatf("status: exp %0d got %0d", exp_r.status, got_r.status));
          if (got_r.count_after !== exp_r.count_after)
            report_fail($sformatf("count_after: exp %0d got %0d",
                                  exp_r.count_after, got_r.count_after));
        end
      end
      if (req_valid_i && req_ready_i)
        predicted_results.push_back(apply_list_op(req_data_i));
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import pobst_pkg::*;

  // Worst case is far below this: ~850 transactions plus stalls and gaps,
  // and a count sweep after reset and every clear.
  localparam int CYCLE_LIMIT = 500_000;
  localparam int N_ITEMS     = 850;
  // Drain wait at the end, once no result is pending.
  localparam int TAIL_CYCLES = 600;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  int       errors;
  int       pending;
  int       cycle_count = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;

  // Hot sets: a few owners and ids get most of the traffic so lists fill up,
  // duplicates show up and removes find their targets.
  logic [OWNER_W-1:0] hot_owner [6];
  logic [ID_W-1:0]    hot_id [12];

  always #4 clk_i = ~clk_i;

  per_owner_bounded_set_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  list_table_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_i(s_axis_tready),
    .req_data_i (s_axis_tdata),
    .rsp_valid_i(m_axis_tvalid),
    .rsp_ready_i(m_axis_tready),
    .rsp_data_i (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** per_owner_bounded_set_table: FAILED **");
      $finish;
    end
  end

  // Result-side backpressure: phases of open, light and heavy stalling
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // tdata: [1:0] action, [2] bank, [10:3] owner_id, [18:11] item_id,
  // [19] owner_eligible, [23:20] zero
  function automatic logic [23:0] req_word(action_e act, logic bnk, logic [7:0] own,
                                           logic [7:0] id, logic elig);
    return {4'b0, elig, id, own, bnk, act};
  endfunction

  function automatic logic [23:0] random_req();
    int         pick;
    action_e    act;
    logic [7:0] own;
    logic [7:0] id;
    pick = $urandom_range(0, 99);
    if (pick < 45) act = ACT_ADD;
    else if (pick < 70) act = ACT_REMOVE;
    else if (pick < 98) act = ACT_CHECK;
    else act = ACT_CLEAR;
    own = ($urandom_range(0, 99) < 85) ? hot_owner[$urandom_range(0, 5)] : 8'($urandom);
    id  = ($urandom_range(0, 99) < 85) ? hot_id[$urandom_range(0, 11)] : 8'($urandom);
    return req_word(act, 1'($urandom), own, id, $urandom_range(0, 9) != 0);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high.
  task automatic send(logic [23:0] word);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = word;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_outstanding();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int sent;
    int burst;
    foreach (hot_owner[i]) hot_owner[i] = 8'($urandom);
    foreach (hot_id[i]) hot_id[i] = 8'($urandom);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: eligibility, extremes, duplicate, bank separation, remove miss,
    // full list (with and without the id in it), middle and tail removal, clear.
    send(req_word(ACT_ADD, 1'b0, 8'h00, 8'h00, 1'b0));
    send(req_word(ACT_ADD, 1'b0, 8'h00, 8'h00, 1'b1));
    send(req_word(ACT_ADD, 1'b0, 8'h00, 8'hFF, 1'b1));
    send(req_word(ACT_ADD, 1'b0, 8'h00, 8'h00, 1'b1));
    send(req_word(ACT_CHECK, 1'b0, 8'h00, 8'hFF, 1'b1));
    send(req_word(ACT_CHECK, 1'b1, 8'h00, 8'hFF, 1'b1));
    send(req_word(ACT_REMOVE, 1'b0, 8'h00, 8'h55, 1'b0));
    send(req_word(ACT_REMOVE, 1'b0, 8'h00, 8'h00, 1'b1));
    send(req_word(ACT_CHECK, 1'b0, 8'h00, 8'hFF, 1'b0));
    for (int i = 0; i < LIST_MAX; i++)
      send(req_word(ACT_ADD, 1'b1, 8'hFF, 8'(1 << i), 1'b1));
    send(req_word(ACT_ADD, 1'b1, 8'hFF, 8'hAA, 1'b1));
    send(req_word(ACT_ADD, 1'b1, 8'hFF, 8'h10, 1'b1));
    send(req_word(ACT_ADD, 1'b1, 8'hFF, 8'h10, 1'b0));
    send(req_word(ACT_REMOVE, 1'b1, 8'hFF, 8'h08, 1'b1));
    send(req_word(ACT_REMOVE, 1'b1, 8'hFF, 8'h80, 1'b1));
    send(req_word(ACT_CLEAR, 1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)));
    send(req_word(ACT_CHECK, 1'b0, 8'h00, 8'hFF, 1'b1));
    send(req_word(ACT_ADD, 1'b1, 8'hFF, 8'h01, 1'b1));

    // Hold off until the block has answered everything
    drain_outstanding();

    // Random bursts with random gaps; a second full drain midway
    sent = 25;
    while (sent < N_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < N_ITEMS; k++) begin
        send(random_req());
        sent++;
        if (sent == N_ITEMS / 2) drain_outstanding();
      end
      s_axis_tvalid = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("** per_owner_bounded_set_table: PASSED **");
    end else begin
      $display("** per_owner_bounded_set_table: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pobst_pkg.sv
hdl/pobst_store.sv
hdl/pobst_seq.sv
hdl/per_owner_bounded_set_table.sv
sim/list_table_checker.sv
sim/tb.sv
